// ----- hdl/ldd_pkg.sv -----
// ----------------------------------------------------------------------------
// ldd_pkg
// Shared sizes, event and status codes, and the structs that pass between the
// sequencer, the lock table and the top level of the deadlock detector.
// ----------------------------------------------------------------------------
package ldd_pkg;

  localparam int THREADS  = 16;
  localparam int LOCKS    = 64;
  localparam int MAX_HOLD = 255;

  localparam int TID_W  = $clog2(THREADS);
  localparam int LID_W  = $clog2(LOCKS);
  localparam int HOLD_W = $clog2(MAX_HOLD + 1);

  localparam int KIND_W = 2;
  localparam int STAT_W = 2;

  localparam logic [KIND_W-1:0] KIND_LOCK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOCKED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_UNLOCK = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
  localparam logic [STAT_W-1:0] ST_DEADLOCK   = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_UNLOCK = 2'd2;
  localparam logic [STAT_W-1:0] ST_SATURATED  = 2'd3;

  typedef struct packed {
    logic [TID_W-1:0]  owner;
    logic [HOLD_W-1:0] count;
  } ldd_lock_ent_t;

  typedef struct packed {
    logic              we;
    logic [LID_W-1:0]  waddr;
    ldd_lock_ent_t     wdata;
    logic [LID_W-1:0]  raddr;
  } ldd_ram_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [TID_W-1:0]  partner;
  } ldd_res_t;

endpackage

// ----- hdl/ldd_in_if.sv -----
// ----------------------------------------------------------------------------
// ldd_in_if
// Event channel: one beat carries one lock event from one thread.
// ----------------------------------------------------------------------------
interface ldd_in_if;

  logic                        valid;
  logic                        ready;
  logic [ldd_pkg::KIND_W-1:0]  kind;
  logic [ldd_pkg::TID_W-1:0]   thread_id;
  logic [ldd_pkg::LID_W-1:0]   lock_id;

  modport source (output valid, output kind, output thread_id, output lock_id,
                  input ready);
  modport sink   (input valid, input kind, input thread_id, input lock_id,
                  output ready);

endinterface

// ----- hdl/ldd_out_if.sv -----
// ----------------------------------------------------------------------------
// ldd_out_if
// Result channel: one beat carries the status of one event.
// ----------------------------------------------------------------------------
interface ldd_out_if;

  logic                        valid;
  logic                        ready;
  logic [ldd_pkg::STAT_W-1:0]  status;
  logic [ldd_pkg::TID_W-1:0]   partner_thread;

  modport source (output valid, output status, output partner_thread,
                  input ready);
  modport sink   (input valid, input status, input partner_thread,
                  output ready);

endinterface

// ----- hdl/ldd_lock_ram.sv -----
// ----------------------------------------------------------------------------
// ldd_lock_ram
// Per-lock owner and hold count table, one write and one registered read per
// cycle. Entries hold no reset value; the sequencer keeps the owned bits.
// ----------------------------------------------------------------------------
module ldd_lock_ram (
  input  logic                  clk,
  input  ldd_pkg::ldd_ram_req_t req,
  output ldd_pkg::ldd_lock_ent_t rd_data
);

  ldd_pkg::ldd_lock_ent_t mem_r [ldd_pkg::LOCKS];
  ldd_pkg::ldd_lock_ent_t rd_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
    rd_r <= mem_r[req.raddr];
  end

  assign rd_data = rd_r;

endmodule

// ----- hdl/ldd_seq.sv -----
// ----------------------------------------------------------------------------
// ldd_seq
// Event sequencer: looks up the lock, updates ownership and the wait slots,
// and walks the waits-for chain one hop per cycle through the lock table.
// ----------------------------------------------------------------------------
module ldd_seq (
  input  logic                   clk,
  input  logic                   rst_n,
  ldd_in_if.sink                 in_ch,
  output ldd_pkg::ldd_ram_req_t  ram_req,
  input  ldd_pkg::ldd_lock_ent_t ram_rdata,
  output logic                   res_valid,
  output ldd_pkg::ldd_res_t      res,
  input  logic                   res_ack
);

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_WALK, S_DONE} state_t;

  state_t                          state_r,  state_nxt;
  logic [ldd_pkg::KIND_W-1:0]      kind_r,   kind_nxt;
  logic [ldd_pkg::TID_W-1:0]       t_r,      t_nxt;
  logic [ldd_pkg::LID_W-1:0]       l_r,      l_nxt;
  logic [ldd_pkg::LID_W-1:0]       lk_r,     lk_nxt;
  logic [ldd_pkg::TID_W-1:0]       hop_r,    hop_nxt;
  logic [ldd_pkg::TID_W-1:0]       cand_r,   cand_nxt;
  ldd_pkg::ldd_res_t               res_r,    res_nxt;
  logic [ldd_pkg::LOCKS-1:0]       ovld_r,   ovld_nxt;
  logic [ldd_pkg::THREADS-1:0]     wvld_r,   wvld_nxt;
  logic [ldd_pkg::LID_W-1:0]       wlock_r   [ldd_pkg::THREADS];
  logic [ldd_pkg::LID_W-1:0]       wlock_nxt [ldd_pkg::THREADS];

  logic                            own_vld;
  logic [ldd_pkg::TID_W-1:0]       own;
  logic [ldd_pkg::HOLD_W-1:0]      cnt;

  assign own = ram_rdata.owner;
  assign cnt = ram_rdata.count;
  // In LOOK the read was for the event's lock, in WALK for the awaited lock.
  assign own_vld = (state_r == S_WALK) ? ovld_r[lk_r] : ovld_r[l_r];

  assign in_ch.ready = (state_r == S_IDLE);
  assign res_valid   = (state_r == S_DONE);
  assign res         = res_r;

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    t_nxt     = t_r;
    l_nxt     = l_r;
    lk_nxt    = lk_r;
    hop_nxt   = hop_r;
    cand_nxt  = cand_r;
    res_nxt   = res_r;
    ovld_nxt  = ovld_r;
    wvld_nxt  = wvld_r;
    wlock_nxt = wlock_r;
    ram_req   = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          kind_nxt      = in_ch.kind;
          t_nxt         = in_ch.thread_id;
          l_nxt         = in_ch.lock_id;
          ram_req.raddr = in_ch.lock_id;
          state_nxt     = S_LOOK;
        end
      end
      S_LOOK: begin
        res_nxt   = '{status: ldd_pkg::ST_OK, partner: '0};
        state_nxt = S_DONE;
        case (kind_r)
          ldd_pkg::KIND_LOCK: begin
            wvld_nxt[t_r]  = 1'b1;
            wlock_nxt[t_r] = l_r;
            if (own_vld && own != t_r) begin
              cand_nxt = own;
              if (wvld_r[own]) begin
                ram_req.raddr = wlock_r[own];
                lk_nxt        = wlock_r[own];
                hop_nxt       = '0;
                state_nxt     = S_WALK;
              end
            end
          end
          ldd_pkg::KIND_LOCKED: begin
            if (wvld_r[t_r] && wlock_r[t_r] == l_r) begin
              wvld_nxt[t_r] = 1'b0;
            end
            ram_req.waddr = l_r;
            if (own_vld && own == t_r) begin
              if (cnt < ldd_pkg::HOLD_W'(ldd_pkg::MAX_HOLD)) begin
                ram_req.we    = 1'b1;
                ram_req.wdata = '{owner: t_r, count: cnt + 1'b1};
              end else begin
                res_nxt.status = ldd_pkg::ST_SATURATED;
              end
            end else begin
              ram_req.we    = 1'b1;
              ram_req.wdata = '{owner: t_r, count: ldd_pkg::HOLD_W'(1)};
              ovld_nxt[l_r] = 1'b1;
            end
          end
          ldd_pkg::KIND_UNLOCK: begin
            ram_req.waddr = l_r;
            if (!own_vld || own != t_r) begin
              res_nxt.status = ldd_pkg::ST_BAD_UNLOCK;
            end else if (cnt <= ldd_pkg::HOLD_W'(1)) begin
              ovld_nxt[l_r] = 1'b0;
            end else begin
              ram_req.we    = 1'b1;
              ram_req.wdata = '{owner: t_r, count: cnt - 1'b1};
            end
          end
          default: begin
          end
        endcase
      end
      S_WALK: begin
        // One hop: compare the owner of the awaited lock, then fetch the lock
        // that this owner waits on for the next hop.
        res_nxt   = '{status: ldd_pkg::ST_OK, partner: '0};
        state_nxt = S_DONE;
        if (own_vld) begin
          if (own == t_r) begin
            res_nxt = '{status: ldd_pkg::ST_DEADLOCK, partner: cand_r};
          end else if (hop_r != ldd_pkg::TID_W'(ldd_pkg::THREADS - 1) && wvld_r[own]) begin
            ram_req.raddr = wlock_r[own];
            lk_nxt        = wlock_r[own];
            hop_nxt       = hop_r + 1'b1;
            state_nxt     = S_WALK;
          end
        end
      end
      S_DONE: begin
        if (res_ack) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovld_r  <= '0;
      wvld_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
      wvld_r  <= wvld_nxt;
    end
    kind_r  <= kind_nxt;
    t_r     <= t_nxt;
    l_r     <= l_nxt;
    lk_r    <= lk_nxt;
    hop_r   <= hop_nxt;
    cand_r  <= cand_nxt;
    res_r   <= res_nxt;
    wlock_r <= wlock_nxt;
  end

  a_accept_to_look: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> state_r == S_LOOK)
    else $error("accepted event did not start a lookup");

  a_deadlock_partner: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && res_r.status == ldd_pkg::ST_DEADLOCK)
      |-> res_r.partner != t_r)
    else $error("deadlock reported against the requesting thread");

  a_partner_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && res_r.status != ldd_pkg::ST_DEADLOCK)
      |-> res_r.partner == '0)
    else $error("partner thread set without a deadlock");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.we |-> ram_req.wdata.count != '0)
    else $error("lock table written with a zero hold count");

  a_walk_from_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> ($past(state_r) == S_LOOK || $past(state_r) == S_WALK))
    else $error("chain walk entered from the wrong state");

endmodule

// ----- hdl/lock_deadlock_detector.sv -----
// Result path: after-lock, before-unlock and unused kinds go from the lookup
// straight to the result register; before-lock may first walk the chain.
// Flow: one event at a time; the walk of the waits-for chain makes one read
// on the lock table's read port per hop.
// Reset: synchronous, active low; reset clears the owned and waiting bits,
// with no clearing pass over the lock table.
// ----------------------------------------------------------------------------
// lock_deadlock_detector
// Tracks lock ownership and thread waits and reports deadlock, invalid unlock
// and hold count saturation, one result beat per event beat.
// ----------------------------------------------------------------------------
module lock_deadlock_detector (
  input  logic     clk,
  input  logic     rst_n,
  ldd_in_if.sink   in_ch,
  ldd_out_if.source out_ch
);

  ldd_pkg::ldd_ram_req_t  ram_req;
  ldd_pkg::ldd_lock_ent_t ram_rdata;
  logic                   res_valid;
  ldd_pkg::ldd_res_t      res;
  logic                   res_take;

  logic                        out_valid_r;
  logic [ldd_pkg::STAT_W-1:0]  out_status_r;
  logic [ldd_pkg::TID_W-1:0]   out_partner_r;

  ldd_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res       (res),
    .res_ack   (res_take)
  );

  ldd_lock_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rdata)
  );

  // The result register frees as soon as its beat is taken.
  assign res_take = res_valid && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (res_take) begin
      out_status_r  <= res.status;
      out_partner_r <= res.partner;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.partner_thread = out_partner_r;

endmodule

// ----- bench/lock_deadlock_detector_tb.sv -----
// ----------------------------------------------------------------------------
// lock_deadlock_detector_tb
// Self-checking bench for the deadlock detector. A short scripted sequence
// covers free, owned and recursive locks, bad unlocks, two- and three-thread
// deadlocks and a waits-for loop that does not include the requester. Random
// acquire and release traffic over shifting pools of locks follows, with a
// saturating hold-count burst and some noise beats. Every accepted event beat
// is run through a lock table model kept here, and each result beat is checked
// in order against it. Random stalls are applied on both channels.
// ----------------------------------------------------------------------------
module lock_deadlock_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ldd_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int TOTAL_EVENTS = 1530;
  localparam int CYCLE_LIMIT = 400_000;
  localparam int SETTLE_CYCLES = 40;
  localparam int SCRIPT_LEN = 27;

  typedef struct packed {
    logic [ldd_pkg::KIND_W-1:0] kind;
    logic [ldd_pkg::TID_W-1:0]  tid;
    logic [ldd_pkg::LID_W-1:0]  lid;
    logic                       typed;
    logic [ldd_pkg::STAT_W-1:0] status;
    logic [ldd_pkg::TID_W-1:0]  partner;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n;

  ldd_in_if  in_bus ();
  ldd_out_if out_bus ();

  lock_deadlock_detector dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  always #1 clk = ~clk;

  // Lock table and wait slots as the block should hold them.
  logic                       lk_held      [ldd_pkg::LOCKS];
  logic [ldd_pkg::TID_W-1:0]  lk_owner     [ldd_pkg::LOCKS];
  int unsigned                lk_count     [ldd_pkg::LOCKS];
  logic                       th_waiting   [ldd_pkg::THREADS];
  logic [ldd_pkg::LID_W-1:0]  th_wait_lock [ldd_pkg::THREADS];

  ldd_pkg::ldd_res_t pending_status [$];
  int                mismatches = 0;
  int                sent = 0;
  int unsigned       cycles = 0;
  bit                idle_on = 1'b1;
  logic [2:0]        pool_base = '0;
  script_row_t       script [SCRIPT_LEN];

  function automatic ldd_pkg::ldd_res_t lock_event_status(
    input logic [ldd_pkg::KIND_W-1:0] kind,
    input logic [ldd_pkg::TID_W-1:0]  tid,
    input logic [ldd_pkg::LID_W-1:0]  lid
  );
    ldd_pkg::ldd_res_t         res;
    logic [ldd_pkg::TID_W-1:0] cur;
    logic                      found;
    logic                      walking;
    res = '0;
    case (kind)
      ldd_pkg::KIND_LOCK: begin
        th_waiting[tid]   = 1'b1;
        th_wait_lock[tid] = lid;
        if (lk_held[lid] && lk_owner[lid] != tid) begin
          cur     = lk_owner[lid];
          found   = 1'b0;
          walking = 1'b1;
          // Follow waiting thread -> awaited lock -> its owner, THREADS hops at most.
          for (int hop = 0; hop < ldd_pkg::THREADS && walking; hop++) begin
            if (!th_waiting[cur] || !lk_held[th_wait_lock[cur]]) begin
              walking = 1'b0;
            end else if (lk_owner[th_wait_lock[cur]] == tid) begin
              found   = 1'b1;
              walking = 1'b0;
            end else begin
              cur = lk_owner[th_wait_lock[cur]];
            end
          end
          if (found) begin
            res.status  = ldd_pkg::ST_DEADLOCK;
            res.partner = lk_owner[lid];
          end
        end
      end
      ldd_pkg::KIND_LOCKED: begin
        if (th_waiting[tid] && th_wait_lock[tid] == lid) th_waiting[tid] = 1'b0;
        if (lk_held[lid] && lk_owner[lid] == tid) begin
          if (lk_count[lid] < ldd_pkg::MAX_HOLD) lk_count[lid]++;
          else res.status = ldd_pkg::ST_SATURATED;
        end else begin
          lk_held[lid]  = 1'b1;
          lk_owner[lid] = tid;
          lk_count[lid] = 1;
        end
      end
      ldd_pkg::KIND_UNLOCK: begin
        if (!lk_held[lid] || lk_owner[lid] != tid) begin
          res.status = ldd_pkg::ST_BAD_UNLOCK;
        end else if (lk_count[lid] <= 1) begin
          lk_count[lid] = 0;
          lk_held[lid]  = 1'b0;
        end else begin
          lk_count[lid]--;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Drives one event beat and records its expected status once it is taken.
  // A typed expectation replaces the computed one but the table still updates.
  task automatic send_event(input logic [ldd_pkg::KIND_W-1:0] kind,
                            input logic [ldd_pkg::TID_W-1:0] tid,
                            input logic [ldd_pkg::LID_W-1:0] lid, input logic typed,
                            input ldd_pkg::ldd_res_t typed_res);
    int                gap;
    ldd_pkg::ldd_res_t res;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.kind      <= kind;
    in_bus.thread_id <= tid;
    in_bus.lock_id   <= lid;
    do @(posedge clk); while (!in_bus.ready);
    res = lock_event_status(kind, tid, lid);
    pending_status.insert(pending_status.size(), typed ? typed_res : res);
    sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
  endtask

  function automatic logic [ldd_pkg::LID_W-1:0] pool_lock();
    if ($urandom_range(0, 7) == 0) begin
      return ldd_pkg::LID_W'($urandom_range(0, ldd_pkg::LOCKS - 1));
    end
    return {pool_base, 3'($urandom_range(0, 7))};
  endfunction

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", field, want, got);
    end
  endtask

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_status.size() == 0) begin
        mismatches++;
        $error("result beat with nothing pending: status %0d, partner_thread %0d",
               out_bus.status, out_bus.partner_thread);
      end else begin
        check_field("status", pending_status[0].status, out_bus.status);
        check_field("partner_thread", pending_status[0].partner, out_bus.partner_thread);
        void'(pending_status.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: a random stall before each beat unless idling is off.
  initial begin
    int stall;
    out_bus.ready = 1'b0;
    forever begin
      stall = idle_on ? $urandom_range(0, 3) : 0;
      @(negedge clk);
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_bus.valid));
    end
  end

  initial begin
    int                         next_shuffle;
    int                         next_drain;
    bit                         burst_done;
    int                         pick;
    int                         tries;
    logic                       found;
    logic [ldd_pkg::TID_W-1:0]  tid;
    logic [ldd_pkg::LID_W-1:0]  lid;

    rst_n            = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.kind      = ldd_pkg::KIND_LOCK;
    in_bus.thread_id = '0;
    in_bus.lock_id   = '0;
    foreach (lk_held[i]) begin
      lk_held[i]  = 1'b0;
      lk_owner[i] = '0;
      lk_count[i] = 0;
    end
    foreach (th_waiting[i]) begin
      th_waiting[i]   = 1'b0;
      th_wait_lock[i] = '0;
    end

    script = '{
      '{ldd_pkg::KIND_LOCKED, 4'd0,  6'd0,  1'b1, ldd_pkg::ST_OK,         4'd0},
      '{ldd_pkg::KIND_UNLOCK, 4'd15, 6'd63, 1'b1, ldd_pkg::ST_BAD_UNLOCK, 4'd0},
      '{KIND_SPARE,           4'd15, 6'd63, 1'b1, ldd_pkg::ST_OK,         4'd0},
      '{ldd_pkg::KIND_LOCK,   4'd15, 6'd63, 1'b1, ldd_pkg::ST_OK,         4'd0},
      '{ldd_pkg::KIND_LOCKED, 4'd15, 6'd63, 1'b1, ldd_pkg::ST_OK,         4'd0},
      '{ldd_pkg::KIND_UNLOCK, 4'd0,  6'd63, 1'b1, ldd_pkg::ST_BAD_UNLOCK, 4'd0},
      '{ldd_pkg::KIND_LOCK,   4'd15, 6'd63, 1'b1, ldd_pkg::ST_OK,         4'd0},
      '{ldd_pkg::KIND_LOCKED, 4'd15, 6'd63, 1'b0, ldd_pkg::ST_OK,         4'd0},
      '{ldd_pkg::KIND_UNLOCK, 4'd15, 6'd63, 1'b0, ldd_pkg::ST_OK,         4'd0},
      '{ldd_pkg::KIND_LOCK,   4'd0,  6'd63, 1'b0, ldd_pkg::ST_OK,         4'd0},
      '{ldd_pkg::KIND_LOCK,   4'd15, 6'd0,  1'b1, ldd_pkg::ST_DEADLOCK,   4'd0},
      '{ldd_pkg::KIND_LOCKED, 4'd0,  6'd63, 1'b0, ldd_pkg::ST_OK,         4'd0},
      '{ldd_pkg::KIND_LOCKED, 4'd1,  6'd1,  1'b0, ldd_pkg::ST_OK,         4'd0},
      '{ldd_pkg::KIND_LOCKED, 4'd2,  6'd2,  1'b0, ldd_pkg::ST_OK,         4'd0},
      '{ldd_pkg::KIND_LOCKED, 4'd3,  6'd3,  1'b0, ldd_pkg::ST_OK,         4'd0},
      '{ldd_pkg::KIND_LOCK,   4'd1,  6'd2,  1'b0, ldd_pkg::ST_OK,         4'd0},
      '{ldd_pkg::KIND_LOCK,   4'd2,  6'd3,  1'b0, ldd_pkg::ST_OK,         4'd0},
      '{ldd_pkg::KIND_LOCK,   4'd3,  6'd1,  1'b1, ldd_pkg::ST_DEADLOCK,   4'd1},
      '{ldd_pkg::KIND_LOCK,   4'd2,  6'd5,  1'b0, ldd_pkg::ST_OK,         4'd0},
      '{ldd_pkg::KIND_LOCK,   4'd3,  6'd1,  1'b0, ldd_pkg::ST_OK,         4'd0},
      '{ldd_pkg::KIND_UNLOCK, 4'd0,  6'd63, 1'b0, ldd_pkg::ST_OK,         4'd0},
      '{ldd_pkg::KIND_UNLOCK, 4'd0,  6'd63, 1'b0, ldd_pkg::ST_OK,         4'd0},
      '{ldd_pkg::KIND_LOCKED, 4'd5,  6'd10, 1'b0, ldd_pkg::ST_OK,         4'd0},
      '{ldd_pkg::KIND_LOCKED, 4'd6,  6'd11, 1'b0, ldd_pkg::ST_OK,         4'd0},
      '{ldd_pkg::KIND_LOCK,   4'd5,  6'd11, 1'b0, ldd_pkg::ST_OK,         4'd0},
      '{ldd_pkg::KIND_LOCK,   4'd6,  6'd10, 1'b1, ldd_pkg::ST_DEADLOCK,   4'd5},
      // Threads 5 and 6 loop on each other, so this walk runs all its hops.
      '{ldd_pkg::KIND_LOCK,   4'd7,  6'd10, 1'b0, ldd_pkg::ST_OK,         4'd0}
    };

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      send_event(script[i].kind, script[i].tid, script[i].lid, script[i].typed,
                 ldd_pkg::ldd_res_t'{script[i].status, script[i].partner});
    end
    drain_results();

    next_shuffle = sent;
    next_drain   = sent + 300;
    burst_done   = 1'b0;
    while (sent < TOTAL_EVENTS) begin
      if (sent >= next_shuffle) begin
        next_shuffle += 100;
        pool_base = 3'($urandom_range(0, 7));
        idle_on   = ($urandom_range(0, 3) != 0);
      end
      if (sent >= next_drain) begin
        next_drain += 300;
        drain_results();
      end
      if (!burst_done && sent >= 600) begin
        // Push one lock's hold count into saturation, then back off a little.
        burst_done = 1'b1;
        tid = ldd_pkg::TID_W'($urandom_range(0, ldd_pkg::THREADS - 1));
        lid = ldd_pkg::LID_W'($urandom_range(0, ldd_pkg::LOCKS - 1));
        send_event(ldd_pkg::KIND_LOCKED, tid, lid, 1'b0, '0);
        while (lk_count[lid] < ldd_pkg::MAX_HOLD) begin
          send_event(ldd_pkg::KIND_LOCKED, tid, lid, 1'b0, '0);
        end
        repeat (2) send_event(ldd_pkg::KIND_LOCKED, tid, lid, 1'b1,
                              ldd_pkg::ldd_res_t'{ldd_pkg::ST_SATURATED, 4'd0});
        repeat (3) send_event(ldd_pkg::KIND_UNLOCK, tid, lid, 1'b0, '0);
        continue;
      end

      pick = $urandom_range(0, 99);
      tid  = ldd_pkg::TID_W'($urandom_range(0, ldd_pkg::THREADS - 1));
      lid  = pool_lock();
      if (pick < 50) begin
        send_event(ldd_pkg::KIND_LOCK, tid, lid, 1'b0, '0);
        if ((!lk_held[lid] || lk_owner[lid] == tid) && $urandom_range(0, 99) < 85) begin
          send_event(ldd_pkg::KIND_LOCKED, tid, lid, 1'b0, '0);
        end
      end else if (pick < 80) begin
        found = 1'b0;
        for (tries = 0; tries < 8 && !found; tries++) begin
          if (lk_held[lid]) found = 1'b1;
          else lid = pool_lock();
        end
        send_event(ldd_pkg::KIND_UNLOCK, found ? lk_owner[lid] : tid, lid, 1'b0, '0);
      end else begin
        send_event(ldd_pkg::KIND_W'($urandom_range(0, 3)), tid,
                   ldd_pkg::LID_W'($urandom_range(0, ldd_pkg::LOCKS - 1)), 1'b0, '0);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
